### rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared widths, phase codes, register indexes, reset values and the
// configuration struct of the ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int LEVEL_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int SENS_W     = 17;
    localparam int GATE_W     = 16;
    localparam int OUT_W      = 25;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // serial multiplier geometry
    localparam int MUL_A_W   = 24;
    localparam int MUL_B_W   = 40;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = 6;

    localparam logic [MUL_CNT_W-1:0] MUL_SHORT_STEPS = MUL_CNT_W'(16);
    localparam logic [MUL_CNT_W-1:0] MUL_LONG_STEPS  = MUL_CNT_W'(MUL_B_W);

    localparam logic [PHASE_W-1:0] PH_SILENCE = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_DECAY   = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SUSTAIN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_SENS     = 3'd5;

    localparam logic [GATE_W-1:0]  GATE_THRESHOLD = 16'd65;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE      = 24'd8388608;
    localparam logic [OUT_W-1:0]   OUT_MAX        = 25'd33554431;

    localparam logic [LEVEL_W-1:0] RST_ATTACK_STEP  = 24'd17476;
    localparam logic [LEVEL_W-1:0] RST_DECAY_STEP   = 24'd350;
    localparam logic [LEVEL_W-1:0] RST_SUSTAIN      = 24'd0;
    localparam logic [LEVEL_W-1:0] RST_RELEASE_STEP = 24'd1748;
    localparam logic [GAIN_W-1:0]  RST_GAIN         = 16'd16384;
    localparam logic [SENS_W-1:0]  RST_VEL_SENS     = 17'd0;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] sustain_level;
        logic [LEVEL_W-1:0] release_step;
        logic [GAIN_W-1:0]  gain;
        logic [SENS_W-1:0]  vel_sens;
    } t_cfg;

endpackage

### rtl/adsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// ADSR envelope generator, one gate word in, one scaled envelope word out.
// ----------------------------------------------------------------------------
// Each accepted gate word advances the envelope by one tick. Its result word
// becomes valid once two bit-serial multiplier passes have run and the word
// is loaded into the output register: level times gain (16 steps, run
// alongside sensitivity times velocity), then that product times the velocity
// factor (40 steps); a new gate word is taken only after that load. A
// finished word waits in the output register while the next gate word is
// processed. Configuration writes are always ready and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module adsr_envelope_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [adsr_pkg::GATE_W-1:0]      i_gate_level,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [adsr_pkg::OUT_W-1:0]       o_envelope_out,
    output logic [adsr_pkg::PHASE_W-1:0]     o_phase_now,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import adsr_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD1 = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_VFAC  = 3'd3;
    localparam logic [2:0] ST_LOAD2 = 3'd4;
    localparam logic [2:0] ST_MUL2  = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    t_cfg cfg;

    logic [2:0]          r_state, n_state;
    logic                in_fire, fin_load;
    logic [LEVEL_W-1:0]  value;
    logic [PHASE_W-1:0]  phase;
    logic [GATE_W-1:0]   velocity;

    logic                m0_start, m1_start, m0_busy, m1_busy;
    logic [MUL_A_W-1:0]  m0_mcand;
    logic [MUL_B_W-1:0]  m0_mplier;
    logic [MUL_CNT_W-1:0] m0_steps;
    logic [MUL_P_W-1:0]  m0_prod, m1_prod;

    logic [32:0]         sv_prod;
    logic [16:0]         q0, r2;
    logic [17:0]         r1, quot;
    logic [1:0]          q1;
    logic signed [18:0]  vfac_t;

    logic [SENS_W-1:0]   r_vfac;
    logic                r_vfac_zero;

    logic [OUT_W-1:0]    env_val;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_env;
    logic [PHASE_W-1:0]  r_phase_out;

    adsr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign in_fire = i_valid && o_ready;

    adsr_phase u_phase (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_fire),
        .i_gate_level (i_gate_level),
        .i_cfg        (cfg),
        .o_value      (value),
        .o_phase      (phase),
        .o_velocity   (velocity)
    );

    // unit 0: level * gain, then that product * velocity factor
    assign m0_start  = (r_state == ST_LOAD1) || (r_state == ST_LOAD2);
    assign m0_mcand  = (r_state == ST_LOAD2) ? {{(MUL_A_W-SENS_W){1'b0}}, r_vfac} : value;
    assign m0_mplier = (r_state == ST_LOAD2) ? m0_prod[MUL_P_W-1:MUL_P_W-MUL_B_W]
                                             : {{(MUL_B_W-GAIN_W){1'b0}}, cfg.gain};
    assign m0_steps  = (r_state == ST_LOAD2) ? MUL_LONG_STEPS : MUL_SHORT_STEPS;

    adsr_ser_mul u_mul0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (m0_start),
        .i_mcand  (m0_mcand),
        .i_mplier (m0_mplier),
        .i_steps  (m0_steps),
        .o_busy   (m0_busy),
        .o_prod   (m0_prod)
    );

    // unit 1: sensitivity * latched velocity
    assign m1_start = r_state == ST_LOAD1;

    adsr_ser_mul u_mul1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (m1_start),
        .i_mcand  ({{(MUL_A_W-SENS_W){1'b0}}, cfg.vel_sens}),
        .i_mplier ({{(MUL_B_W-GATE_W){1'b0}}, velocity}),
        .i_steps  (MUL_SHORT_STEPS),
        .o_busy   (m1_busy),
        .o_prod   (m1_prod)
    );

    // floor(x / 65535) by folding the high half back onto the low half
    assign sv_prod = m1_prod[MUL_P_W-MUL_B_W+32:MUL_P_W-MUL_B_W];
    assign q0      = sv_prod[32:16];
    assign r1      = {2'b00, sv_prod[15:0]} + {1'b0, q0};
    assign q1      = r1[17:16];
    assign r2      = {1'b0, r1[15:0]} + {15'd0, q1};
    assign quot    = {1'b0, q0} + {16'd0, q1} + {17'd0, (r2 >= 17'd65535)};
    assign vfac_t  = signed'(19'd65536) + signed'({1'b0, quot})
                   - signed'({2'b00, cfg.vel_sens});

    always_ff @(posedge i_clk) begin
        if (r_state == ST_VFAC) begin
            r_vfac      <= vfac_t[SENS_W-1:0];
            r_vfac_zero <= vfac_t[18] || (vfac_t == '0);
        end
    end

    // prod >> 30 with saturation; a factor at or below zero gives silence
    always_comb begin
        if (r_vfac_zero) begin
            env_val = '0;
        end else if (|m0_prod[MUL_P_W-1:55]) begin
            env_val = OUT_MAX;
        end else begin
            env_val = m0_prod[54:30];
        end
    end

    assign fin_load = (r_state == ST_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_LOAD1;
            ST_LOAD1: n_state = ST_MUL1;
            ST_MUL1:  if (!m0_busy && !m1_busy) n_state = ST_VFAC;
            ST_VFAC:  n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_MUL2;
            ST_MUL2:  if (!m0_busy) n_state = ST_FIN;
            ST_FIN:   if (fin_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_env       <= env_val;
            r_phase_out <= phase;
        end
    end

    assign o_ready        = r_state == ST_IDLE;
    assign o_valid        = r_out_valid;
    assign o_envelope_out = r_env;
    assign o_phase_now    = r_phase_out;
    assign o_cfg_ready    = 1'b1;

endmodule

### rtl/adsr_cfg.sv
// ----------------------------------------------------------------------------
// adsr_cfg
// Configuration register file; writes beyond the register list are dropped.
// ----------------------------------------------------------------------------
module adsr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output adsr_pkg::t_cfg                   o_cfg
);
    import adsr_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step   <= RST_ATTACK_STEP;
            r_cfg.decay_step    <= RST_DECAY_STEP;
            r_cfg.sustain_level <= RST_SUSTAIN;
            r_cfg.release_step  <= RST_RELEASE_STEP;
            r_cfg.gain          <= RST_GAIN;
            r_cfg.vel_sens      <= RST_VEL_SENS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK_STEP:  r_cfg.attack_step   <= i_cfg_data[LEVEL_W-1:0];
                CFG_DECAY_STEP:   r_cfg.decay_step    <= i_cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN:      r_cfg.sustain_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_RELEASE_STEP: r_cfg.release_step  <= i_cfg_data[LEVEL_W-1:0];
                CFG_GAIN:         r_cfg.gain          <= i_cfg_data[GAIN_W-1:0];
                CFG_VEL_SENS:     r_cfg.vel_sens      <= i_cfg_data[SENS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/adsr_phase.sv
// ----------------------------------------------------------------------------
// adsr_phase
// Gate edge detection, velocity latch and one-tick advance of the envelope
// phase and level.
// ----------------------------------------------------------------------------
module adsr_phase (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [adsr_pkg::GATE_W-1:0]    i_gate_level,
    input  adsr_pkg::t_cfg                 i_cfg,
    output logic [adsr_pkg::LEVEL_W-1:0]   o_value,
    output logic [adsr_pkg::PHASE_W-1:0]   o_phase,
    output logic [adsr_pkg::GATE_W-1:0]    o_velocity
);
    import adsr_pkg::*;

    logic [LEVEL_W-1:0] r_level, n_level;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [GATE_W-1:0]  r_vel, n_vel;
    logic               r_prev_gate;
    logic [LEVEL_W-1:0] r_value, n_value;

    logic               gate_on;
    logic [PHASE_W-1:0] ph_in;
    logic [LEVEL_W:0]   sum_att;
    logic signed [LEVEL_W+1:0] diff_dec, diff_rel, sus_ext;

    assign gate_on  = i_gate_level > GATE_THRESHOLD;
    assign sum_att  = {1'b0, r_level} + {1'b0, i_cfg.attack_step};
    assign diff_dec = signed'({2'b00, r_level}) - signed'({2'b00, i_cfg.decay_step});
    assign diff_rel = signed'({2'b00, r_level}) - signed'({2'b00, i_cfg.release_step});
    assign sus_ext  = signed'({2'b00, i_cfg.sustain_level});

    always_comb begin
        // an edge takes effect before this tick's advance
        ph_in = r_phase;
        n_vel = r_vel;
        if (gate_on && !r_prev_gate) begin
            ph_in = PH_ATTACK;
            n_vel = i_gate_level;
        end else if (!gate_on && r_prev_gate) begin
            ph_in = PH_RELEASE;
        end

        n_level = r_level;
        n_phase = ph_in;
        n_value = r_level;
        unique case (ph_in)
            PH_ATTACK: begin
                if (sum_att >= {1'b0, LEVEL_ONE}) begin
                    n_level = LEVEL_ONE;
                    n_phase = PH_DECAY;
                end else begin
                    n_level = sum_att[LEVEL_W-1:0];
                end
                n_value = n_level;
            end
            PH_DECAY: begin
                if (diff_dec <= sus_ext) begin
                    n_level = i_cfg.sustain_level;
                    n_phase = PH_SUSTAIN;
                end else begin
                    n_level = diff_dec[LEVEL_W-1:0];
                end
                n_value = n_level;
            end
            PH_SUSTAIN: n_value = i_cfg.sustain_level;
            PH_RELEASE: begin
                if (diff_rel <= 0) begin
                    n_level = '0;
                    n_phase = PH_SILENCE;
                end else begin
                    n_level = diff_rel[LEVEL_W-1:0];
                end
                n_value = n_level;
            end
            default: begin
                n_phase = PH_SILENCE;
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_phase     <= PH_SILENCE;
            r_vel       <= '0;
            r_prev_gate <= 1'b0;
        end else if (i_step) begin
            r_level     <= n_level;
            r_phase     <= n_phase;
            r_vel       <= n_vel;
            r_prev_gate <= gate_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_value <= n_value;
        end
    end

    assign o_value    = r_value;
    assign o_phase    = r_phase;
    assign o_velocity = r_vel;

endmodule

### rtl/adsr_ser_mul.sv
// ----------------------------------------------------------------------------
// adsr_ser_mul
// Bit-serial shift-add multiplier: one multiplier bit per cycle, LSB first.
// After n steps the product sits in o_prod[MUL_P_W-1 -: MUL_A_W+n].
// ----------------------------------------------------------------------------
module adsr_ser_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [adsr_pkg::MUL_A_W-1:0]     i_mcand,
    input  logic [adsr_pkg::MUL_B_W-1:0]     i_mplier,
    input  logic [adsr_pkg::MUL_CNT_W-1:0]   i_steps,
    output logic                             o_busy,
    output logic [adsr_pkg::MUL_P_W-1:0]     o_prod
);
    import adsr_pkg::*;

    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_P_W-1:0]   r_prod, n_prod;
    logic [MUL_A_W-1:0]   r_mcand;
    logic [MUL_B_W-1:0]   r_mplier;
    logic [MUL_A_W-1:0]   addend;
    logic [MUL_A_W:0]     top_sum;

    assign addend  = r_mplier[0] ? r_mcand : '0;
    assign top_sum = {1'b0, r_prod[MUL_P_W-1:MUL_B_W]} + {1'b0, addend};
    // add into the top, then shift the whole product right one place
    assign n_prod  = {top_sum, r_prod[MUL_B_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= i_steps;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod   <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_cnt != '0) begin
            r_prod   <= n_prod;
            r_mplier <= {1'b0, r_mplier[MUL_B_W-1:1]};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_prod = r_prod;

endmodule
